// File: src/hge_pkg.sv
// ----------------------------------------------------------------------------
// HTTP GET host extractor package
// Shared constants, byte codes, match patterns and the classification word
// that travels from the front end to the parser through the queue.
// ----------------------------------------------------------------------------
package hge_pkg;

  localparam int MAX_PAYLOAD_DEF = 2048;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Widths of the result fields.
  localparam int OFF_W    = 11;
  localparam int LEN_W    = 12;
  localparam int RESULT_W = 72;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [31:0] PAT_GET     = 32'h4745_5420;  // "GET "
  localparam logic [31:0] PAT_HOST_UC = 32'h486F_7374;  // "Host"
  localparam logic [31:0] PAT_HOST_LC = 32'h686F_7374;  // "host"
  localparam logic [31:0] PAT_REFE    = 32'h5265_6665;  // "Refe"
  localparam logic [31:0] PAT_RER     = 32'h7265_723A;  // "rer:"

  // Classification of one payload byte, made at the front end.
  typedef struct packed {
    logic last;      // final byte of the payload
    logic overflow;  // byte lies beyond the largest payload
    logic pos3;      // byte is at offset three
    logic is_sp;
    logic is_tab;
    logic is_cr;
    logic is_lf;
    logic is_colon;
    logic prev_cr;   // byte before this one is CR
    logic get_hit;   // last four bytes are "GET "
    logic host_hit;  // last four bytes are "Host" or "host" and follow an LF
    logic refe_hit;  // last four bytes are "Refe" and follow an LF
    logic rer_hit;   // last four bytes are "rer:"
  } hge_flags_t;

endpackage

// File: src/hge_front.sv
// ----------------------------------------------------------------------------
// HTTP GET host extractor front end
// Accepts payload bytes, keeps the byte offset and a four-byte window, and
// turns each byte into a classification word for the parser.
// ----------------------------------------------------------------------------
module hge_front #(
  parameter int MAX_PAYLOAD = hge_pkg::MAX_PAYLOAD_DEF,
  parameter int POS_W       = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                push_ready,
  output logic                push,
  output hge_pkg::hge_flags_t flags,
  output logic [POS_W-1:0]    pos_out
);

  logic [POS_W-1:0] pos;
  logic [31:0]      window;
  logic [31:0]      window_next;
  logic             line_start;

  assign push        = in_valid && push_ready;
  assign pos_out     = pos;
  assign window_next = {window[23:0], in_byte};
  // The byte that falls out of the window is the one before a four-byte match.
  assign line_start  = (window[31:24] == hge_pkg::CH_LF);

  always_comb begin
    flags.last     = in_last;
    flags.overflow = (pos >= POS_W'(MAX_PAYLOAD));
    flags.pos3     = (pos == POS_W'(3));
    flags.is_sp    = (in_byte == hge_pkg::CH_SP);
    flags.is_tab   = (in_byte == hge_pkg::CH_TAB);
    flags.is_cr    = (in_byte == hge_pkg::CH_CR);
    flags.is_lf    = (in_byte == hge_pkg::CH_LF);
    flags.is_colon = (in_byte == hge_pkg::CH_COLON);
    flags.prev_cr  = (window[7:0] == hge_pkg::CH_CR);
    flags.get_hit  = (window_next == hge_pkg::PAT_GET);
    flags.host_hit = line_start && ((window_next == hge_pkg::PAT_HOST_UC) ||
                                    (window_next == hge_pkg::PAT_HOST_LC));
    flags.refe_hit = line_start && (window_next == hge_pkg::PAT_REFE);
    flags.rer_hit  = (window_next == hge_pkg::PAT_RER);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      window <= '0;
    end else if (push) begin
      if (in_last) begin
        pos    <= '0;
        window <= '0;
      end else if (!flags.overflow) begin
        pos    <= pos + POS_W'(1);
        window <= window_next;
      end
    end
  end

endmodule

// File: src/hge_queue.sv
// ----------------------------------------------------------------------------
// HTTP GET host extractor queue
// Short first-in first-out queue between the front end and the parser.
// ----------------------------------------------------------------------------
module hge_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = hge_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/hge_back.sv
// ----------------------------------------------------------------------------
// HTTP GET host extractor parser
// Runs the request parse over classified bytes and registers one result word
// at the final byte of each payload.
// ----------------------------------------------------------------------------
module hge_back #(
  parameter int POS_W = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  hge_pkg::hge_flags_t             in_flags,
  input  logic [POS_W-1:0]                in_pos,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [hge_pkg::RESULT_W-1:0]    m_tdata
);

  typedef enum logic [12:0] {
    PH_PREFIX      = 13'b0_0000_0000_0001,
    PH_URL_SKIP    = 13'b0_0000_0000_0010,
    PH_URL_BODY    = 13'b0_0000_0000_0100,
    PH_HOST_SEARCH = 13'b0_0000_0000_1000,
    PH_HOST_COLON  = 13'b0_0000_0001_0000,
    PH_HOST_SPACE  = 13'b0_0000_0010_0000,
    PH_HOST_VALUE  = 13'b0_0000_0100_0000,
    PH_REF_SEARCH  = 13'b0_0000_1000_0000,
    PH_REF_TAIL    = 13'b0_0001_0000_0000,
    PH_REF_SKIP    = 13'b0_0010_0000_0000,
    PH_REF_VALUE   = 13'b0_0100_0000_0000,
    PH_REF_NONE    = 13'b0_1000_0000_0000,
    PH_REF_DONE    = 13'b1_0000_0000_0000
  } phase_t;

  phase_t           phase, phase_next;
  logic             failed, failed_next;
  logic             host_cut, host_cut_next;
  logic [POS_W-1:0] url_begin, url_begin_next;
  logic [POS_W-1:0] url_finish, url_finish_next;
  logic [POS_W-1:0] host_begin, host_begin_next;
  logic [POS_W-1:0] host_finish, host_finish_next;
  logic [POS_W-1:0] ref_begin, ref_begin_next;
  logic [POS_W-1:0] ref_finish, ref_finish_next;
  logic [POS_W:0]   ref_colon_pos;

  logic             ok;
  logic             ref_ok;
  logic [POS_W-1:0] url_len, host_span, ref_len;
  logic [POS_W+hge_pkg::LEN_W-1:0] url_off_x, url_len_x, host_off_x, host_span_x;
  logic [POS_W+hge_pkg::LEN_W-1:0] ref_off_x, ref_len_x;
  logic [hge_pkg::RESULT_W-1:0]    result;

  // A result word may only leave when the output register is free.
  assign pop = in_valid && (!in_flags.last || !m_tvalid || m_tready);

  assign ref_colon_pos = {1'b0, ref_begin} + (POS_W + 1)'(4);

  always_comb begin
    phase_next       = phase;
    failed_next      = failed;
    host_cut_next    = host_cut;
    url_begin_next   = url_begin;
    url_finish_next  = url_finish;
    host_begin_next  = host_begin;
    host_finish_next = host_finish;
    ref_begin_next   = ref_begin;
    ref_finish_next  = ref_finish;

    if (in_flags.overflow) begin
      failed_next = 1'b1;
    end else if (!failed) begin
      unique case (phase)
        PH_PREFIX: begin
          if (in_flags.pos3) begin
            if (in_flags.get_hit) phase_next = PH_URL_SKIP;
            else failed_next = 1'b1;
          end
        end
        PH_URL_SKIP: begin
          if (in_flags.is_cr || in_flags.is_lf) begin
            failed_next = 1'b1;
          end else if (!in_flags.is_sp) begin
            url_begin_next = in_pos;
            phase_next     = PH_URL_BODY;
          end
        end
        PH_URL_BODY: begin
          if (in_flags.is_sp) begin
            url_finish_next = in_pos;
            phase_next      = PH_HOST_SEARCH;
          end else if (in_flags.is_cr || in_flags.is_lf) begin
            failed_next = 1'b1;
          end
        end
        PH_HOST_SEARCH: begin
          if (in_flags.host_hit) phase_next = PH_HOST_COLON;
        end
        PH_HOST_COLON: begin
          if (in_flags.is_colon) phase_next = PH_HOST_SPACE;
          else failed_next = 1'b1;
        end
        PH_HOST_SPACE: begin
          if (in_flags.is_sp) begin
            host_begin_next = in_pos + POS_W'(1);
            phase_next      = PH_HOST_VALUE;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_HOST_VALUE: begin
          if (in_flags.is_lf) begin
            // A trailing CR is not part of the host.
            if (!host_cut) begin
              host_finish_next = in_flags.prev_cr ? in_pos - POS_W'(1) : in_pos;
            end
            phase_next = PH_REF_SEARCH;
          end else if (in_flags.is_colon && !host_cut) begin
            host_cut_next    = 1'b1;
            host_finish_next = in_pos;
          end
        end
        PH_REF_SEARCH: begin
          if (in_flags.refe_hit) begin
            ref_begin_next = in_pos;
            phase_next     = PH_REF_TAIL;
          end
        end
        PH_REF_TAIL: begin
          if ({1'b0, in_pos} == ref_colon_pos) begin
            phase_next = in_flags.rer_hit ? PH_REF_SKIP : PH_REF_NONE;
          end
        end
        PH_REF_SKIP: begin
          if (!in_flags.is_sp && !in_flags.is_tab) begin
            ref_begin_next = in_pos;
            phase_next     = PH_REF_VALUE;
          end
        end
        PH_REF_VALUE: begin
          if (in_flags.is_sp || in_flags.is_tab || in_flags.is_cr || in_flags.is_lf) begin
            ref_finish_next = in_pos;
            phase_next      = PH_REF_DONE;
          end
        end
        PH_REF_NONE, PH_REF_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign ok     = !failed_next && (phase_next inside {PH_REF_SEARCH, PH_REF_TAIL,
                                   PH_REF_SKIP, PH_REF_VALUE, PH_REF_NONE, PH_REF_DONE});
  assign ref_ok = ok && (phase_next == PH_REF_DONE);

  assign url_len   = url_finish_next - url_begin_next;
  assign host_span = host_finish_next - host_begin_next;
  assign ref_len   = ref_finish_next - ref_begin_next;

  // Widen before cutting so that any offset width maps onto the field widths.
  assign url_off_x   = {{hge_pkg::LEN_W{1'b0}}, url_begin_next};
  assign url_len_x   = {{hge_pkg::LEN_W{1'b0}}, url_len};
  assign host_off_x  = {{hge_pkg::LEN_W{1'b0}}, host_begin_next};
  assign host_span_x = {{hge_pkg::LEN_W{1'b0}}, host_span};
  assign ref_off_x   = {{hge_pkg::LEN_W{1'b0}}, ref_begin_next};
  assign ref_len_x   = {{hge_pkg::LEN_W{1'b0}}, ref_len};

  always_comb begin
    result = '0;
    if (ok) begin
      result[0]     = 1'b1;
      result[11:1]  = url_off_x[hge_pkg::OFF_W-1:0];
      result[23:12] = url_len_x[hge_pkg::LEN_W-1:0];
      result[34:24] = host_off_x[hge_pkg::OFF_W-1:0];
      result[46:35] = host_span_x[hge_pkg::LEN_W-1:0];
    end
    if (ref_ok) begin
      result[47]    = 1'b1;
      result[58:48] = ref_off_x[hge_pkg::OFF_W-1:0];
      result[70:59] = ref_len_x[hge_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_PREFIX;
      failed   <= 1'b0;
      host_cut <= 1'b0;
    end else if (pop) begin
      if (in_flags.last) begin
        phase    <= PH_PREFIX;
        failed   <= 1'b0;
        host_cut <= 1'b0;
      end else begin
        phase    <= phase_next;
        failed   <= failed_next;
        host_cut <= host_cut_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      url_begin   <= url_begin_next;
      url_finish  <= url_finish_next;
      host_begin  <= host_begin_next;
      host_finish <= host_finish_next;
      ref_begin   <= ref_begin_next;
      ref_finish  <= ref_finish_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && in_flags.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && in_flags.last) begin
      m_tdata <= result;
    end
  end

endmodule

// File: src/http_get_host_extractor_core.sv
// ----------------------------------------------------------------------------
// HTTP GET host extractor
// Finds the URL, Host and optional Referer fields of a GET request payload.
// ----------------------------------------------------------------------------
// The block takes one TCP payload byte per word and sustains one word per
// cycle while s_tready is high; the parser takes one byte each cycle while
// the queue holds bytes and, at a last byte, the output register is free.
// A QUEUE_DEPTH-entry queue between the byte classifier and the parser lets
// either side stall. Exactly one result word leaves for each payload, held
// in an output register so the next payload can flow in while it waits.
// When found is low every result field is zero, and the referer fields are
// zero when referer_found is low. Bytes beyond MAX_PAYLOAD fail the parse.
module http_get_host_extractor_core #(
  parameter int MAX_PAYLOAD = hge_pkg::MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = hge_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] found, [11:1] url_offset, [23:12] url_size, [34:24] host_offset,
  // [46:35] host_size, [47] referer_found, [58:48] referer_offset,
  // [70:59] referer_length, [71] zero
  output logic [71:0] m_tdata
);

  localparam int POS_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int FLAG_W = $bits(hge_pkg::hge_flags_t);
  localparam int Q_W    = FLAG_W + POS_W;

  logic                push;
  hge_pkg::hge_flags_t front_flags;
  logic [POS_W-1:0]    front_pos;
  logic [Q_W-1:0]      q_out;
  logic                q_valid;
  logic                pop;
  hge_pkg::hge_flags_t back_flags;
  logic [POS_W-1:0]    back_pos;

  hge_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .POS_W       (POS_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .push_ready (s_tready),
    .push       (push),
    .flags      (front_flags),
    .pos_out    (front_pos)
  );

  hge_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({front_flags, front_pos}),
    .push_ready (s_tready),
    .pop        (pop),
    .pop_valid  (q_valid),
    .pop_data   (q_out)
  );

  assign back_flags = hge_pkg::hge_flags_t'(q_out[Q_W-1:POS_W]);
  assign back_pos   = q_out[POS_W-1:0];

  hge_back #(
    .POS_W (POS_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_flags (back_flags),
    .in_pos   (back_pos),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
